### hdl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command codes, port widths and the control and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [1:0] CMD_POP_BACK   = 2'd1;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd2;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd3;

    localparam int CMD_W     = 2;
    localparam int FIELD_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } deq_ctrl_t;

    typedef struct packed {
        logic slot_free;
    } deq_stat_t;

endpackage : deq_pkg
`default_nettype wire

### hdl/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Steps each command through capture, execute, store read and result load.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire deq_stat_t stat,
    output deq_ctrl_t      ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.exec    = 1'b0;
        ctrl.read    = 1'b0;
        ctrl.load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ctrl.read  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.slot_free)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : deq_ctrl
`default_nettype wire

### hdl/deq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring store, front and back pointers, entry count and the result register.
// ----------------------------------------------------------------------------
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CMD_W-1:0]      in_cmd,
    input  wire logic [FIELD_W-1:0]    in_value,
    input  wire deq_ctrl_t             ctrl,
    output deq_stat_t                  stat,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PTR_LAST : p - PW'(1);
    endfunction

    logic [VALUE_WIDTH-1:0] ring_mem [DEPTH];

    logic [CMD_W-1:0]        cmd_reg;
    logic [FIELD_W-1:0]      value_reg;
    logic [PW-1:0]           front_reg;
    logic [PW-1:0]           front_next;
    logic [PW-1:0]           back_reg;
    logic [PW-1:0]           back_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    wr_en;
    logic [PW-1:0]           wr_addr;
    logic [VALUE_WIDTH-1:0]  wr_word;
    logic [VALUE_WIDTH+FIELD_W-1:0] wr_ext;
    logic [VALUE_WIDTH-1:0]  rd_front_reg;
    logic [VALUE_WIDTH-1:0]  rd_back_reg;
    logic [VALUE_WIDTH+FIELD_W-1:0] front_ext;
    logic [VALUE_WIDTH+FIELD_W-1:0] back_ext;
    logic [CW+COUNT_W-1:0]   count_ext;
    logic                    full;
    logic                    empty;
    logic                    res_valid_reg;
    logic [COUNT_W-1:0]      res_count_reg;
    logic                    res_empty_reg;
    logic [FIELD_W-1:0]      res_front_reg;
    logic [FIELD_W-1:0]      res_back_reg;
    logic                    res_ovf_reg;

    assign full    = (count_reg == COUNT_FULL);
    assign empty   = (count_reg == '0);
    assign wr_ext  = {{VALUE_WIDTH{1'b0}}, value_reg};
    assign wr_word = wr_ext[VALUE_WIDTH-1:0];

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        ovf_next   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = back_reg;
        case (cmd_reg)
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = back_reg;
                    back_next  = ptr_inc(back_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (!empty)
                begin
                    back_next  = ptr_dec(back_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = ptr_dec(front_reg);
                    front_next = ptr_dec(front_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (!empty)
                begin
                    front_next = ptr_inc(front_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
        end
        if (ctrl.exec)
        begin
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && wr_en)
        begin
            ring_mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            rd_front_reg <= ring_mem[front_reg];
            rd_back_reg  <= ring_mem[ptr_dec(back_reg)];
        end
    end

    assign front_ext = {{FIELD_W{rd_front_reg[VALUE_WIDTH-1]}}, rd_front_reg};
    assign back_ext  = {{FIELD_W{rd_back_reg[VALUE_WIDTH-1]}}, rd_back_reg};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            res_count_reg <= count_ext[COUNT_W-1:0];
            res_empty_reg <= empty;
            res_front_reg <= empty ? '0 : front_ext[FIELD_W-1:0];
            res_back_reg  <= empty ? '0 : back_ext[FIELD_W-1:0];
            res_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign stat.slot_free = !res_valid_reg || m_tready;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_ovf_reg, res_back_reg, res_front_reg,
                       res_empty_reg, res_count_reg};

endmodule : deq_datapath
`default_nettype wire

### hdl/double_ended_queue.sv
`default_nettype none
// The result is registered after the execute, store read and result load states
// that follow the input transfer. A new command is accepted only when the last one
// has passed the ring store sequence of write, registered two-port read and result load.
// A result waiting in the output register holds the next command at result load.
// Reset clears the pointers, the entry count and the control state; the ring
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed values in a ring store, one result per command.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // value[31:0]
    input  wire logic [CMD_W-1:0]      s_tuser,  // command[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // count[6:0], empty_res[7], front_value[39:8], back_value[71:40],
    // overflow[72], zero fill[79:73]
    output logic [M_TDATA_W-1:0]       m_tdata
);

    deq_ctrl_t ctrl;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    deq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_cmd   (s_tuser),
        .in_value (s_tdata),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule : double_ended_queue
`default_nettype wire

### hdl/deq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped before transfer");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed before transfer");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |-> (m_tdata[71:8] == '0))
        else $error("empty queue reports nonzero front or back");

    a_ovf_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[72] |-> !m_tdata[7])
        else $error("overflow reported on an empty queue");

endmodule : deq_checker

bind double_ended_queue deq_checker u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
